[rtl/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants for the linear block code encoder / corrector.
// ----------------------------------------------------------------------------
package lbc_pkg;

    // fixed field widths of the stream payload
    localparam int WORD_W     = 7;
    localparam int DATA_OUT_W = 4;
    localparam int SYN_W      = 3;

    // widest vector any legal parameter set needs
    localparam int MAX_W = 8;

    // configuration register widths
    localparam int GEN_W      = 28;
    localparam int CHK_W      = 21;
    localparam int CFG_DATA_W = 28;
    localparam int CFG_IDX_W  = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GEN_MATRIX   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_MATRIX = 1'b1;

    // reset values: hamming (7,4) check matrix H; GEN_RESET differs from its hamming generator in one tap
    localparam logic [GEN_W-1:0] GEN_RESET = 28'd153783431;
    localparam logic [CHK_W-1:0] CHK_RESET = 21'd1405816;

    // default code geometry
    localparam int DATA_BITS_DEF  = 4;
    localparam int CODE_BITS_DEF  = 7;
    localparam int CHECK_BITS_DEF = 3;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    typedef enum logic {
        CMD_ENCODE  = 1'b0,
        CMD_CORRECT = 1'b1
    } cmd_t;

    // accepted input item
    typedef struct packed {
        cmd_t              cmd;
        logic [WORD_W-1:0] word;
    } in_item_t;

    // item after the xor trees
    typedef struct packed {
        cmd_t             cmd;
        logic [MAX_W-1:0] cw;
        logic [MAX_W-1:0] data;
        logic [MAX_W-1:0] syn;
    } mid_item_t;

    // finished result
    typedef struct packed {
        logic [WORD_W-1:0]     codeword;
        logic [DATA_OUT_W-1:0] data_out;
        logic [SYN_W-1:0]      syndrome;
        logic                  error_seen;
        logic                  uncorrectable;
    } res_item_t;

endpackage

[rtl/lbc_correct.sv]
// ----------------------------------------------------------------------------
// lbc_correct
// Matches the syndrome against the columns of H, flips the first matching
// codeword bit and builds the result item.
// ----------------------------------------------------------------------------
module lbc_correct #(
    parameter int DATA_BITS  = lbc_pkg::DATA_BITS_DEF,
    parameter int CODE_BITS  = lbc_pkg::CODE_BITS_DEF,
    parameter int CHECK_BITS = lbc_pkg::CHECK_BITS_DEF
) (
    input  logic [lbc_pkg::CHK_W-1:0] check_matrix,
    input  lbc_pkg::mid_item_t        mid,
    output lbc_pkg::res_item_t        res
);

    localparam logic [lbc_pkg::MAX_W-1:0] DMASK =
        lbc_pkg::MAX_W'((1 << DATA_BITS) - 1);

    logic [CODE_BITS-1:0][CHECK_BITS-1:0] hcol;
    logic [CHECK_BITS-1:0]                syn;
    logic                                 err;
    logic [CODE_BITS-1:0]                 match;
    logic [CODE_BITS-1:0]                 first;
    logic [lbc_pkg::MAX_W-1:0]            fixed;
    logic [lbc_pkg::MAX_W-1:0]            dec_data;
    logic [lbc_pkg::MAX_W-1:0]            sel_data;

    // columns of H, bits past the register read as zero
    for (genvar c = 0; c < CODE_BITS; c++) begin : g_col
        for (genvar r = 0; r < CHECK_BITS; r++) begin : g_row
            localparam int POS = r * CODE_BITS + c;
            if (POS < lbc_pkg::CHK_W) begin : g_in
                assign hcol[c][r] = check_matrix[POS];
            end else begin : g_out
                assign hcol[c][r] = 1'b0;
            end
        end
        assign match[c] = err && (hcol[c] == syn);
    end

    assign syn = mid.syn[CHECK_BITS-1:0];
    assign err = |syn;

    // lowest matching column wins
    assign first = match & (~match + CODE_BITS'(1));

    assign fixed    = mid.cw ^ lbc_pkg::MAX_W'(first);
    assign dec_data = fixed & DMASK;
    assign sel_data = (mid.cmd == lbc_pkg::CMD_CORRECT) ? dec_data : mid.data;

    // result fields
    always_comb begin
        res.codeword      = fixed[lbc_pkg::WORD_W-1:0];
        res.data_out      = sel_data[lbc_pkg::DATA_OUT_W-1:0];
        res.syndrome      = mid.syn[lbc_pkg::SYN_W-1:0];
        res.error_seen    = err;
        res.uncorrectable = err && !(|match);
    end

endmodule

[rtl/linear_block_code_encode_correct.sv]
// Stages: input, xor-tree and correction registers (s0_reg, s1_reg, s2_reg), in that
// order; a result is valid on m_tdata once its item has passed through all of them.
// Throughput: one item per cycle; a stalled output holds the pipeline, no bubbles.
// Reset: aresetn synchronous active low, empties the pipeline and loads the
// hamming (7,4) parity-check matrix H and the GEN_RESET generator matrix.
// ----------------------------------------------------------------------------
// linear_block_code_encode_correct
// Streaming single-error-correcting block code: encode by G, or compute the
// syndrome by H and repair one bit.
// ----------------------------------------------------------------------------
module linear_block_code_encode_correct #(
    parameter int DATA_BITS  = lbc_pkg::DATA_BITS_DEF,
    parameter int CODE_BITS  = lbc_pkg::CODE_BITS_DEF,
    parameter int CHECK_BITS = lbc_pkg::CHECK_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lbc_pkg::S_TDATA_W-1:0]   s_tdata,  // word_in[6:0], zero pad[7]
    input  logic                            s_tuser,  // cmd
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // codeword[6:0], data_out[10:7], syndrome[13:11], zero pad[15:14]
    output logic [lbc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [lbc_pkg::M_TUSER_W-1:0]   m_tuser   // error_seen[0], uncorrectable[1]
);

    localparam logic [lbc_pkg::MAX_W-1:0] DMASK =
        lbc_pkg::MAX_W'((1 << DATA_BITS) - 1);

    logic [lbc_pkg::GEN_W-1:0] gen_reg;
    logic [lbc_pkg::CHK_W-1:0] chk_reg;

    logic                 v0_reg, v1_reg, v2_reg;
    logic                 rdy0, rdy1, rdy2;
    lbc_pkg::in_item_t    s0_reg;
    lbc_pkg::mid_item_t   s1_reg, s1_next;
    lbc_pkg::res_item_t   s2_reg, s2_next;

    logic [CODE_BITS-1:0][DATA_BITS-1:0]  gcol;
    logic [CHECK_BITS-1:0][CODE_BITS-1:0] hrow;
    logic [lbc_pkg::MAX_W-1:0]            word_ext;
    logic [lbc_pkg::MAX_W-1:0]            enc_data;
    logic [CODE_BITS-1:0]                 enc_cw;
    logic [CODE_BITS-1:0]                 rx_cw;
    logic [CHECK_BITS-1:0]                syn;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg <= lbc_pkg::GEN_RESET;
            chk_reg <= lbc_pkg::CHK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lbc_pkg::REG_GEN_MATRIX:   gen_reg <= cfg_data[lbc_pkg::GEN_W-1:0];
                lbc_pkg::REG_CHECK_MATRIX: chk_reg <= cfg_data[lbc_pkg::CHK_W-1:0];
                default: ;
            endcase
        end
    end

    // per-stage ready, a stage advances when its successor can take it
    assign rdy2     = !v2_reg || m_tready;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign s_tready = rdy0;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg <= s_tvalid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && rdy0) begin
            s0_reg.cmd  <= lbc_pkg::cmd_t'(s_tuser);
            s0_reg.word <= s_tdata[lbc_pkg::WORD_W-1:0];
        end
        if (v0_reg && rdy1) s1_reg <= s1_next;
        if (v1_reg && rdy2) s2_reg <= s2_next;
    end

    // matrix taps, bits past the register read as zero
    for (genvar i = 0; i < CODE_BITS; i++) begin : g_gcol
        for (genvar j = 0; j < DATA_BITS; j++) begin : g_grow
            localparam int POS = j * CODE_BITS + i;
            if (POS < lbc_pkg::GEN_W) begin : g_in
                assign gcol[i][j] = gen_reg[POS];
            end else begin : g_out
                assign gcol[i][j] = 1'b0;
            end
        end
        assign enc_cw[i] = ^(enc_data[DATA_BITS-1:0] & gcol[i]);
    end

    for (genvar r = 0; r < CHECK_BITS; r++) begin : g_hrow
        for (genvar c = 0; c < CODE_BITS; c++) begin : g_hcol
            localparam int POS = r * CODE_BITS + c;
            if (POS < lbc_pkg::CHK_W) begin : g_in
                assign hrow[r][c] = chk_reg[POS];
            end else begin : g_out
                assign hrow[r][c] = 1'b0;
            end
        end
        assign syn[r] = ^(rx_cw & hrow[r]);
    end

    // xor trees: codeword by G, syndrome by H
    assign word_ext = lbc_pkg::MAX_W'(s0_reg.word);
    assign enc_data = word_ext & DMASK;
    assign rx_cw    = word_ext[CODE_BITS-1:0];

    always_comb begin
        s1_next.cmd = s0_reg.cmd;
        if (s0_reg.cmd == lbc_pkg::CMD_CORRECT) begin
            s1_next.cw   = lbc_pkg::MAX_W'(rx_cw);
            s1_next.data = '0;
            s1_next.syn  = lbc_pkg::MAX_W'(syn);
        end else begin
            s1_next.cw   = lbc_pkg::MAX_W'(enc_cw);
            s1_next.data = enc_data;
            s1_next.syn  = '0;
        end
    end

    // column match and bit repair
    lbc_correct #(
        .DATA_BITS  (DATA_BITS),
        .CODE_BITS  (CODE_BITS),
        .CHECK_BITS (CHECK_BITS)
    ) u_correct (
        .check_matrix (chk_reg),
        .mid          (s1_reg),
        .res          (s2_next)
    );

    // result stream
    assign m_tvalid = v2_reg;
    assign m_tdata  = {2'b00, s2_reg.syndrome, s2_reg.data_out, s2_reg.codeword};
    assign m_tuser  = {s2_reg.uncorrectable, s2_reg.error_seen};

endmodule

[rtl/lbc_checker.sv]
// ----------------------------------------------------------------------------
// lbc_checker
// Port-level checks on the block code encoder / corrector, bound to the top.
// ----------------------------------------------------------------------------
module lbc_checker #(
    parameter int CHECK_BITS = lbc_pkg::CHECK_BITS_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lbc_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [lbc_pkg::M_TUSER_W-1:0]  m_tuser
);

    localparam bit WIDE_SYN = (CHECK_BITS > lbc_pkg::SYN_W);

    // the pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result keeps its content
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // an uncorrectable word is always an error word
    a_unc_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("uncorrectable without error flag");

    // error flag follows the reported syndrome
    a_err_syn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> WIDE_SYN || (m_tuser[0] == (m_tdata[13:11] != 3'd0)))
        else $error("error flag disagrees with syndrome");

    // transfers toward the empty pipeline are never refused
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && $past(!m_tvalid) && $past(!m_tvalid, 2) && $past(!s_tvalid, 3)
        && $past(aresetn, 3) |-> s_tready)
        else $error("input refused while pipeline empty");

endmodule

bind linear_block_code_encode_correct lbc_checker #(
    .CHECK_BITS (CHECK_BITS)
) u_lbc_checker (.*);
